// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while the block is out of reset.
`define SQSV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SQSV_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/sqsv_pkg.sv -----
`timescale 1ns / 1ps

package sqsv_pkg;

  localparam int unsigned DEF_SINE_DEPTH = 256;
  localparam int unsigned DEF_TIME_BITS  = 20;
  localparam int unsigned DEF_PHASE_BITS = 32;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Envelope values are Q16 with 65536 = 1.0.
  localparam int unsigned Q16_W = 17;
  localparam logic [Q16_W-1:0] Q16_ONE = 17'd65536;

  localparam logic [15:0] RST_OUT_GAIN   = 16'd16384;
  localparam logic [30:0] RST_BASE_STEP  = 31'd39370534;
  localparam logic [30:0] RST_LFO_STEP   = 31'd447392;
  localparam logic [59:0] RST_AMP_TIMES  = 60'd15832977506308800;
  localparam logic [59:0] RST_FREQ_TIMES = 60'd15832977506308800;
  localparam logic [63:0] RST_LEVELS     = 64'd1844815149583807283;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_GAIN   = 3'd0,
    REG_BASE_STEP  = 3'd1,
    REG_LFO_STEP   = 3'd2,
    REG_AMP_TIMES  = 3'd3,
    REG_FREQ_TIMES = 3'd4,
    REG_LEVELS     = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    NOTE_IDLE     = 2'd0,
    NOTE_HELD     = 2'd1,
    NOTE_RELEASED = 2'd2
  } note_e;

  // One entry of the sine table, evaluated at elaboration only. The phase index
  // is spread over 16 bits, folded into a quarter wave and run through a
  // seventh order Taylor series in Q30.
  function automatic logic [15:0] sine_entry(input int unsigned idx, input int unsigned lg);
    logic [63:0] u, q, quad, theta, x2, t, s;
    u = (64'(idx) << (16 - lg)) & 64'hFFFF;
    quad = u >> 14;
    q = u & 64'h3FFF;
    if (quad[0]) begin
      q = 64'd16384 - q;
    end
    theta = q * 64'd102944;
    x2 = (theta * theta) >> 30;
    t = (64'd1 << 30) - x2 / 64'd42;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
    s = ((theta * t) >> 30) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return (quad >= 64'd2) ? (~s[15:0] + 16'd1) : s[15:0];
  endfunction

endpackage

// ----- rtl/core/square_synth_voice_adsr_lfo.sv -----
`timescale 1ns / 1ps

// Channel    Direction  Handshake              Payload
// s_axis     in         tvalid / tready        tdata[1:0] note_state
// m_axis     out        tvalid / tready        tdata[15:0] sample, tuser channel, tlast last
// cfg        in         cfg_we_i               cfg_idx_i register, cfg_wdata_i value
//
// One frame request runs at most two envelope divisions through the shared
// restoring divider, then two samples through the shared multiplier, nine
// steps each.
// Input ready is low from acceptance until the right sample is loaded.
// A stalled output holds the sequencer before its next sample is loaded.
// Reset clears the time count, release start, phases and note history; no clearing pass is needed.
module square_synth_voice_adsr_lfo import sqsv_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = DEF_SINE_DEPTH,
  parameter int unsigned TIME_BITS        = DEF_TIME_BITS,
  parameter int unsigned PHASE_BITS       = DEF_PHASE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [1:0] note_state
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [15:0] sample
  output logic                  m_axis_tuser,   // [0] channel
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

`include "assert_macros.svh"

  localparam int unsigned TB      = TIME_BITS;
  localparam int unsigned TC_W    = TIME_BITS + 2;
  localparam int unsigned TIMES_W = 3 * TIME_BITS;
  localparam int unsigned PB      = PHASE_BITS;
  localparam int unsigned LG      = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned NUM_W   = TIME_BITS + Q16_W;
  localparam int unsigned MA_W    = 33;
  localparam int unsigned MB_W    = 19;
  localparam int unsigned MP_W    = MA_W + MB_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ENV, ST_NUM, ST_DIV, ST_FSTEP, ST_FSTEPR, ST_LFO1, ST_ROM1,
    ST_MOD, ST_STEP, ST_OSC, ST_ROM2, ST_AMPM, ST_GAIN, ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    ENV_ATTACK, ENV_DECAY, ENV_RELEASE, ENV_SUSTAIN, ENV_OFF
  } env_mode_e;

  // Configuration registers.
  logic [15:0] gain_q;
  logic [30:0] base_q, lfo_step_q;
  logic [59:0] amp_times_q, freq_times_q;
  logic [63:0] levels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= RST_OUT_GAIN;
      base_q <= RST_BASE_STEP;
      lfo_step_q <= RST_LFO_STEP;
      amp_times_q <= RST_AMP_TIMES;
      freq_times_q <= RST_FREQ_TIMES;
      levels_q <= RST_LEVELS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OUT_GAIN:   gain_q <= cfg_wdata_i[15:0];
        REG_BASE_STEP:  base_q <= cfg_wdata_i[30:0];
        REG_LFO_STEP:   lfo_step_q <= cfg_wdata_i[30:0];
        REG_AMP_TIMES:  amp_times_q <= cfg_wdata_i[59:0];
        REG_FREQ_TIMES: freq_times_q <= cfg_wdata_i[59:0];
        REG_LEVELS:     levels_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sine table, registered read.
  logic [15:0] sine_rom [SINE_TABLE_DEPTH];
  logic [15:0] rom_q;

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, LG);
  end

  // Voice state and sequencer registers.
  state_e           state_q;
  env_mode_e        mode_q;
  logic [1:0]       note_q, prev_q;
  logic [TC_W-1:0]  tc_q, rs_q;
  logic [PB-1:0]    osc_q, lfo_q;
  logic             sel_q, k_q, high_q;
  logic [Q16_W:0]   env_pitch_q;
  logic [Q16_W-1:0] env_amp_q;
  logic [TB-1:0]    den_q;
  logic [31:0]      fstep_q;
  logic             out_valid_q, out_k_q;
  logic [15:0]      out_data_q;
  logic signed [MP_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    rom_q <= sine_rom[lfo_q[PB-1 -: LG]];
  end

  // Envelope selection for the current pass (pitch first, then amplitude).
  logic [TIMES_W-1:0] times_ext;
  logic [TB-1:0]    t_a, t_d, t_r;
  logic [15:0]      lvl_s;
  logic [TC_W-1:0]  rel;
  logic [TB:0]      a_plus_d;
  env_mode_e        mode_d;
  logic [TB-1:0]    env_num_a, env_den;
  logic [Q16_W-1:0] env_num_b;

  always_comb begin
    times_ext = TIMES_W'(sel_q ? amp_times_q : freq_times_q);
    t_a = times_ext[0 +: TB];
    t_d = times_ext[TB +: TB];
    t_r = times_ext[2*TB +: TB];
    lvl_s = sel_q ? levels_q[15:0] : levels_q[31:16];
    rel = (tc_q >= rs_q) ? (tc_q - rs_q) : '0;
    a_plus_d = {1'b0, t_a} + {1'b0, t_d};
    mode_d = ENV_OFF;
    env_num_a = '0;
    env_num_b = '0;
    env_den = t_a;
    if (note_q == NOTE_HELD) begin
      if (tc_q < TC_W'(t_a)) begin
        mode_d = ENV_ATTACK;
        env_num_a = tc_q[TB-1:0];
        env_num_b = Q16_ONE;
      end else if (tc_q < TC_W'(a_plus_d)) begin
        mode_d = ENV_DECAY;
        env_num_a = tc_q[TB-1:0] - t_a;
        env_num_b = Q16_ONE - {1'b0, lvl_s};
        env_den = t_d;
      end else begin
        mode_d = ENV_SUSTAIN;
      end
    end else if (note_q == NOTE_RELEASED && rel < TC_W'(t_r)) begin
      mode_d = ENV_RELEASE;
      env_num_a = t_r - rel[TB-1:0];
      env_num_b = {1'b0, lvl_s};
      env_den = t_r;
    end
  end

  // Shared divider.
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_quot;
  logic [Q16_W-1:0] q17;

  assign div_start = (state_q == ST_NUM);
  assign q17 = div_quot[Q16_W-1:0];

  sqsv_div #(
    .NUM_W (NUM_W),
    .DEN_W (TB)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q[NUM_W-1:0]),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Products divided by 2^15 or 2^17, truncated toward zero.
  logic signed [32:0] lfo_prod;
  logic signed [17:0] lfo_term;
  logic signed [19:0] fact;
  logic signed [18:0] amp;
  logic signed [35:0] gain_prod;
  logic signed [18:0] v, v_sgn;
  logic [15:0]        v_sat;

  always_comb begin
    lfo_prod = prod_q[32:0];
    lfo_term = 18'((lfo_prod + (lfo_prod[32] ? 33'sd32767 : 33'sd0)) >>> 15);
    fact = 20'sd65536 + 20'(lfo_term);
    amp = $signed({2'b0, env_amp_q}) + 19'(lfo_term);
    gain_prod = prod_q[35:0];
    v = 19'((gain_prod + (gain_prod[35] ? 36'sd131071 : 36'sd0)) >>> 17);
    v_sgn = high_q ? v : -v;
    if (v_sgn > 19'sd32767) begin
      v_sat = 16'h7FFF;
    end else if (v_sgn < -19'sd32768) begin
      v_sat = 16'h8000;
    end else begin
      v_sat = v_sgn[15:0];
    end
  end

  // Shared multiplier operands.
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_ENV: begin
        mul_a = $signed(MA_W'(env_num_a));
        mul_b = $signed(MB_W'(env_num_b));
      end
      ST_FSTEP: begin
        mul_a = $signed(MA_W'(base_q));
        mul_b = $signed(MB_W'(env_pitch_q));
      end
      ST_MOD: begin
        mul_a = $signed(MA_W'(levels_q[63:48]));
        mul_b = MB_W'($signed(rom_q));
      end
      ST_STEP: begin
        mul_a = $signed({1'b0, fstep_q});
        mul_b = fact[MB_W-1:0];
      end
      ST_AMPM: begin
        mul_a = $signed(MA_W'(levels_q[47:32]));
        mul_b = MB_W'($signed(rom_q));
      end
      ST_GAIN: begin
        mul_a = MA_W'(amp);
        mul_b = $signed(MB_W'(gain_q));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  logic in_acc, out_acc, out_load;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q <= ENV_OFF;
      note_q <= NOTE_IDLE;
      prev_q <= NOTE_IDLE;
      tc_q <= '0;
      rs_q <= '0;
      osc_q <= '0;
      lfo_q <= '0;
      sel_q <= 1'b0;
      k_q <= 1'b0;
      high_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_k_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            note_q <= s_axis_tdata[1:0];
            if (s_axis_tdata[1:0] == NOTE_RELEASED && prev_q != NOTE_RELEASED) begin
              rs_q <= tc_q;
            end
            sel_q <= 1'b0;
            state_q <= ST_ENV;
          end
        end
        ST_ENV: begin
          mode_q <= mode_d;
          den_q <= env_den;
          if (mode_d == ENV_ATTACK || mode_d == ENV_DECAY || mode_d == ENV_RELEASE) begin
            state_q <= ST_NUM;
          end else begin
            if (sel_q) begin
              env_amp_q <= (mode_d == ENV_SUSTAIN) ? {1'b0, lvl_s} : '0;
              state_q <= ST_FSTEP;
            end else begin
              env_pitch_q <= (mode_d == ENV_SUSTAIN) ? {2'b0, lvl_s} : {1'b0, Q16_ONE};
              sel_q <= 1'b1;
            end
          end
        end
        ST_NUM: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            if (sel_q) begin
              unique case (mode_q)
                ENV_ATTACK: env_amp_q <= q17;
                ENV_DECAY:  env_amp_q <= Q16_ONE - q17;
                default:    env_amp_q <= q17;
              endcase
              state_q <= ST_FSTEP;
            end else begin
              unique case (mode_q)
                ENV_ATTACK: env_pitch_q <= {1'b0, Q16_ONE} + {1'b0, q17};
                ENV_DECAY:  env_pitch_q <= {Q16_ONE, 1'b0} - {1'b0, q17};
                default:    env_pitch_q <= {1'b0, q17};
              endcase
              sel_q <= 1'b1;
              state_q <= ST_ENV;
            end
          end
        end
        ST_FSTEP: state_q <= ST_FSTEPR;
        ST_FSTEPR: begin
          fstep_q <= prod_q[47:16];
          k_q <= 1'b0;
          state_q <= ST_LFO1;
        end
        ST_LFO1: begin
          lfo_q <= lfo_q + PB'(lfo_step_q);
          state_q <= ST_ROM1;
        end
        ST_ROM1: state_q <= ST_MOD;
        ST_MOD:  state_q <= ST_STEP;
        ST_STEP: state_q <= ST_OSC;
        ST_OSC: begin
          high_q <= !osc_q[PB-1];
          osc_q <= osc_q + prod_q[16 +: PB];
          lfo_q <= lfo_q + PB'(lfo_step_q);
          state_q <= ST_ROM2;
        end
        ST_ROM2: state_q <= ST_AMPM;
        ST_AMPM: state_q <= ST_GAIN;
        ST_GAIN: state_q <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            out_data_q <= v_sat;
            out_k_q <= k_q;
            if (!k_q) begin
              k_q <= 1'b1;
              state_q <= ST_LFO1;
            end else begin
              if (tc_q != '1) begin
                tc_q <= tc_q + TC_W'(1);
              end
              prev_q <= note_q;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_k_q;
  assign m_axis_tlast = out_k_q;

  `SQSV_ASSERT(a_busy_after_req, in_acc |=> !s_axis_tready, "input taken while busy")
  `SQSV_ASSERT(a_time_monotonic, tc_q >= $past(tc_q), "time count went backward")
  `SQSV_ASSERT(a_div_in_div_state, div_done |-> state_q == ST_DIV, "divider done out of step")

endmodule

// ----- rtl/core/sqsv_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module sqsv_div import sqsv_pkg::*; #(
  parameter int unsigned NUM_W = 37,
  parameter int unsigned DEN_W = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]   shifted, trial;
  logic             fits;

  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    trial = shifted - {1'b0, den_q};
    fits = (shifted >= {1'b0, den_q});
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
